[src/gttc_pkg.sv]
// ----------------------------------------------------------------------------
// GPS time to calendar package
// Item types, arithmetic constants and small tables shared by the pipeline.
// ----------------------------------------------------------------------------
package gttc_pkg;

  localparam int NumStages = 10;

  typedef struct packed {
    logic [15:0] week_number;
    logic [31:0] ms_of_week;
  } in_t;

  typedef struct packed {
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [15:0] ms_of_minute;
  } out_t;

  typedef struct packed {
    logic [15:0] week;
    logic [5:0]  days;
    logic [26:0] ms_day;
  } split_t;

  localparam logic [26:0] MsPerDay     = 27'd86400000;
  localparam logic [21:0] MsPerHour    = 22'd3600000;
  localparam logic [15:0] MsPerMinute  = 16'd60000;
  localparam logic [11:0] DayRecip     = 12'd3181;
  localparam logic [9:0]  HourRecip    = 10'd596;
  localparam logic [11:0] MinuteRecip  = 12'd2236;
  localparam logic [19:0] CycleRecip   = 20'd734924;
  localparam logic [10:0] DaysPerCycle = 11'd1461;
  localparam logic [8:0]  DaysPerYear  = 9'd365;
  localparam logic [14:0] EpochOffset  = 15'd28859;
  localparam logic [10:0] BaseYear     = 11'd1901;

  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
    logic [8:0] base;
    unique case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      4'd12:   base = 9'd365;
      default: base = 9'd0;
    endcase
    return base + ((leap && (idx >= 4'd2)) ? 9'd1 : 9'd0);
  endfunction

  function automatic logic [3:0] month_guess(input logic [8:0] yday);
    logic [10:0] yday4;
    logic [3:0]  g;
    yday4 = {yday, 2'b00};
    g = 4'd0;
    for (int k = 1; k <= 11; k++) begin
      if (yday4 >= 11'(125 * k)) begin
        g = g + 4'd1;
      end
    end
    return g;
  endfunction

endpackage

[src/gttc_day_split.sv]
// ----------------------------------------------------------------------------
// GPS time to calendar: day split
// Splits the millisecond count into whole days and milliseconds of the day.
// ----------------------------------------------------------------------------
module gttc_day_split (
  input  logic                              clk_i,
  input  logic [gttc_pkg::NumStages-1:0]    en_i,
  input  gttc_pkg::in_t                     in_i,
  output gttc_pkg::split_t                  split_o
);
  import gttc_pkg::*;

  logic [33:0] est_prod;
  logic [5:0]  est_d, est0_q, est1_q;
  logic [31:0] ms0_q, ms1_q;
  logic [15:0] wk0_q, wk1_q;
  logic [31:0] prod_d, prod_q;
  logic [31:0] diff;
  logic [27:0] over;
  logic        ge;
  split_t      split_d, split_q;

  always_comb begin
    est_prod = 34'(in_i.ms_of_week[31:10]) * 34'(DayRecip);
    est_d    = est_prod[33:28];
    prod_d   = 32'(est0_q) * 32'(MsPerDay);
    diff     = ms1_q - prod_q;
    over     = diff[27:0] - 28'(MsPerDay);
    ge       = diff[27:0] >= 28'(MsPerDay);
    split_d.week   = wk1_q;
    split_d.days   = est1_q + 6'(ge);
    split_d.ms_day = ge ? over[26:0] : diff[26:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      est0_q <= est_d;
      ms0_q  <= in_i.ms_of_week;
      wk0_q  <= in_i.week_number;
    end
    if (en_i[1]) begin
      prod_q <= prod_d;
      est1_q <= est0_q;
      ms1_q  <= ms0_q;
      wk1_q  <= wk0_q;
    end
    if (en_i[2]) begin
      split_q <= split_d;
    end
  end

  assign split_o = split_q;

endmodule

[src/gttc_date.sv]
// ----------------------------------------------------------------------------
// GPS time to calendar: date
// Turns the day count into year, month and day of month.
// ----------------------------------------------------------------------------
module gttc_date (
  input  logic                           clk_i,
  input  logic [gttc_pkg::NumStages-1:0] en_i,
  input  gttc_pkg::split_t               split_i,
  output logic [11:0]                    year_o,
  output logic [3:0]                     month_o,
  output logic [4:0]                     day_o
);
  import gttc_pkg::*;

  logic [18:0] since_d, since3_q, since4_q, since5_q;
  logic [38:0] cyc_prod;
  logic [8:0]  cest_d, cest4_q, cest5_q;
  logic [18:0] cprod_d, cprod_q;
  logic [11:0] dl0;
  logic        cge;
  logic [8:0]  cyc_d, cyc_q;
  logic [10:0] dl_d, dl_q;
  logic [1:0]  dyears;
  logic [8:0]  yday_d, yday7_q, yday8_q;
  logic [11:0] year_d, year7_q, year8_q, year9_q;
  logic        leap7_q, leap8_q;
  logic [3:0]  guess_d, guess_q;
  logic        more;
  logic [3:0]  month_d, month_q;
  logic [8:0]  day_full;
  logic [4:0]  day_q;

  always_comb begin
    since_d  = 19'(split_i.week) * 19'd7 + 19'(split_i.days) + 19'(EpochOffset);
    cyc_prod = 39'(since3_q) * 39'(CycleRecip);
    cest_d   = cyc_prod[38:30];
    cprod_d  = 19'(cest4_q) * 19'(DaysPerCycle);
    dl0      = 12'(since5_q - cprod_q);
    cge      = dl0 >= 12'(DaysPerCycle);
    cyc_d    = cest5_q + 9'(cge);
    dl_d     = cge ? 11'(dl0 - 12'(DaysPerCycle)) : dl0[10:0];
    dyears   = 2'(dl_q >= 11'd365) + 2'(dl_q >= 11'd730) + 2'(dl_q >= 11'd1095);
    yday_d   = 9'(dl_q - 11'(dyears) * 11'(DaysPerYear) + 11'd1);
    year_d   = 12'(BaseYear) + {1'b0, cyc_q, 2'b00} + 12'(dyears);
    guess_d  = month_guess(yday7_q);
    more     = yday8_q > month_start(leap8_q, guess_q + 4'd1);
    month_d  = guess_q + 4'(more) + 4'd1;
    day_full = yday8_q - month_start(leap8_q, guess_q + 4'(more));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      since3_q <= since_d;
    end
    if (en_i[4]) begin
      cest4_q  <= cest_d;
      since4_q <= since3_q;
    end
    if (en_i[5]) begin
      cprod_q  <= cprod_d;
      cest5_q  <= cest4_q;
      since5_q <= since4_q;
    end
    if (en_i[6]) begin
      cyc_q <= cyc_d;
      dl_q  <= dl_d;
    end
    if (en_i[7]) begin
      yday7_q <= yday_d;
      year7_q <= year_d;
      leap7_q <= (dyears == 2'd3);
    end
    if (en_i[8]) begin
      guess_q <= guess_d;
      yday8_q <= yday7_q;
      year8_q <= year7_q;
      leap8_q <= leap7_q;
    end
    if (en_i[9]) begin
      month_q <= month_d;
      day_q   <= day_full[4:0];
      year9_q <= year8_q;
    end
  end

  assign year_o  = year9_q;
  assign month_o = month_q;
  assign day_o   = day_q;

endmodule

[src/gttc_clock.sv]
// ----------------------------------------------------------------------------
// GPS time to calendar: time of day
// Splits milliseconds of the day into hour, minute and milliseconds.
// ----------------------------------------------------------------------------
module gttc_clock (
  input  logic                           clk_i,
  input  logic [gttc_pkg::NumStages-1:0] en_i,
  input  logic [26:0]                    ms_day_i,
  output logic [4:0]                     hour_o,
  output logic [5:0]                     minute_o,
  output logic [15:0]                    msm_o
);
  import gttc_pkg::*;

  logic [29:0] hour_prod;
  logic [4:0]  hest_d, hest3_q, hest4_q;
  logic [26:0] msd3_q, msd4_q;
  logic [26:0] hprod_d, hprod_q;
  logic [26:0] rem0;
  logic        hge;
  logic [4:0]  hour_d, hour5_q, hour6_q, hour7_q, hour8_q, hour9_q;
  logic [21:0] rem_d, rem5_q, rem6_q, rem7_q;
  logic [28:0] min_prod;
  logic [5:0]  mest_d, mest6_q, mest7_q, mest8_q;
  logic [21:0] mprod_d, mprod_q;
  logic [21:0] msm0_full;
  logic [16:0] msm0_q;
  logic        mge;
  logic [16:0] msm_sub;
  logic [5:0]  minute_q;
  logic [15:0] msm_q;

  always_comb begin
    hour_prod = 30'(ms_day_i[26:7]) * 30'(HourRecip);
    hest_d    = hour_prod[28:24];
    hprod_d   = 27'(hest3_q) * 27'(MsPerHour);
    rem0      = msd4_q - hprod_q;
    hge       = rem0[22:0] >= 23'(MsPerHour);
    hour_d    = hest4_q + 5'(hge);
    rem_d     = hge ? 22'(rem0[22:0] - 23'(MsPerHour)) : rem0[21:0];
    min_prod  = 29'(rem5_q[21:5]) * 29'(MinuteRecip);
    mest_d    = min_prod[27:22];
    mprod_d   = 22'(mest6_q) * 22'(MsPerMinute);
    msm0_full = rem7_q - mprod_q;
    mge       = msm0_q >= 17'(MsPerMinute);
    msm_sub   = msm0_q - 17'(MsPerMinute);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      hest3_q <= hest_d;
      msd3_q  <= ms_day_i;
    end
    if (en_i[4]) begin
      hprod_q <= hprod_d;
      hest4_q <= hest3_q;
      msd4_q  <= msd3_q;
    end
    if (en_i[5]) begin
      hour5_q <= hour_d;
      rem5_q  <= rem_d;
    end
    if (en_i[6]) begin
      mest6_q <= mest_d;
      rem6_q  <= rem5_q;
      hour6_q <= hour5_q;
    end
    if (en_i[7]) begin
      mprod_q <= mprod_d;
      mest7_q <= mest6_q;
      rem7_q  <= rem6_q;
      hour7_q <= hour6_q;
    end
    if (en_i[8]) begin
      msm0_q  <= msm0_full[16:0];
      mest8_q <= mest7_q;
      hour8_q <= hour7_q;
    end
    if (en_i[9]) begin
      minute_q <= mest8_q + 6'(mge);
      msm_q    <= mge ? msm_sub[15:0] : msm0_q[15:0];
      hour9_q  <= hour8_q;
    end
  end

  assign hour_o   = hour9_q;
  assign minute_o = minute_q;
  assign msm_o    = msm_q;

endmodule

[src/gps_time_to_calendar_core.sv]
// The pipeline has ten register stages.
// Throughput: one item per cycle unless the output stalls; each of the ten stages holds its own item.
// Each stage moves on whenever the stage after it is empty or moving, so bubbles
// are squeezed out while the output is stalled.
// Reset clears the stage valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
// GPS time to calendar core
// Converts GPS week and milliseconds of week into calendar date and time.
// ----------------------------------------------------------------------------
module gps_time_to_calendar_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  gttc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output gttc_pkg::out_t out_data_o
);
  import gttc_pkg::*;

  logic [NumStages-1:0] valid_d, valid_q;
  logic [NumStages-1:0] ready;
  split_t               split;
  logic [11:0]          year;
  logic [3:0]           month;
  logic [4:0]           day;
  logic [4:0]           hour;
  logic [5:0]           minute;
  logic [15:0]          msm;

  always_comb begin
    ready[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      ready[i] = !valid_q[i] || ready[i+1];
    end
    valid_d = {valid_q[NumStages-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int i = 0; i < NumStages; i++) begin
        if (ready[i]) begin
          valid_q[i] <= valid_d[i];
        end
      end
    end
  end

  gttc_day_split u_day_split (
    .clk_i   (clk_i),
    .en_i    (ready),
    .in_i    (in_data_i),
    .split_o (split)
  );

  gttc_date u_date (
    .clk_i   (clk_i),
    .en_i    (ready),
    .split_i (split),
    .year_o  (year),
    .month_o (month),
    .day_o   (day)
  );

  gttc_clock u_clock (
    .clk_i    (clk_i),
    .en_i     (ready),
    .ms_day_i (split.ms_day),
    .hour_o   (hour),
    .minute_o (minute),
    .msm_o    (msm)
  );

  always_comb begin
    out_data_o.year_out     = year;
    out_data_o.month_out    = month;
    out_data_o.day_out      = day;
    out_data_o.hour_out     = hour;
    out_data_o.minute_out   = minute;
    out_data_o.ms_of_minute = msm;
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[NumStages-1];

endmodule

[src/gttc_checker.sv]
// ----------------------------------------------------------------------------
// GPS time to calendar checker
// Port-level properties of the core, attached by a bind statement.
// ----------------------------------------------------------------------------
module gttc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input gttc_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input gttc_pkg::out_t out_data_o
);
  import gttc_pkg::*;

  logic unused_in;
  assign unused_in = in_valid_i ^ (^in_data_i);

  // The input is only held back when the whole pipeline is full and blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the pipeline can move");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while the output is free");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result item changed or vanished");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.year_out >= 12'd1980 &&
                     out_data_o.month_out >= 4'd1 && out_data_o.month_out <= 4'd12 &&
                     out_data_o.day_out >= 5'd1 && out_data_o.hour_out <= 5'd23 &&
                     out_data_o.minute_out <= 6'd59 &&
                     out_data_o.ms_of_minute <= 16'd59999))
    else $error("result item field out of range");

endmodule

bind gps_time_to_calendar_core gttc_checker u_checker (.*);
